[hdl/zpnc_pkg.sv]
// Shared types, constants and the neighbor count function of the zero pixel neighbor count unit.
package zpnc_pkg;

   localparam int DEFAULT_MAX_WIDTH = 64;
   localparam int DEFAULT_MAX_HEIGHT = 64;

   localparam int CFG_W = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int RESET_FRAME_SIZE = 8;
   localparam int MIN_FRAME_SIZE = 3;

   localparam int ROW_OUT_W = 6;
   localparam int COL_OUT_W = 6;
   localparam int COUNT_W = 4;
   localparam int NEIGHBORS = 8;

   localparam int WINDOW_W = 9;
   localparam int CENTER_BIT = 4;
   localparam logic [WINDOW_W-1:0] NEIGHBOR_MASK = 9'h1EF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // One pixel as it sits in the stage register, with its position already resolved.
   typedef struct packed {
      logic                 pixel_bit;
      logic                 frame_start;
      logic                 report_ok;
      logic [ROW_OUT_W-1:0] center_row;
      logic [COL_OUT_W-1:0] center_col;
   } zpnc_item_type;

   // The two stored rows at one column.
   typedef struct packed {
      logic middle;
      logic upper;
   } zpnc_column_type;

   function automatic logic [COUNT_W-1:0] count_neighbors(input logic [WINDOW_W-1:0] window);
      logic [COUNT_W-1:0]  total;
      logic [WINDOW_W-1:0] masked;
      total = '0;
      masked = window & NEIGHBOR_MASK;
      for (int i = 0; i < WINDOW_W; i++) begin
         total = total + COUNT_W'(masked[i]);
      end
      return total;
   endfunction

endpackage

[hdl/zpnc_if.sv]
// Valid/ready channel interfaces for the pixel input and the result output.
interface zpnc_req_if;
   logic valid;
   logic ready;
   logic pixel_bit;
   logic frame_start;

   modport source (output valid, output pixel_bit, output frame_start, input ready);
   modport sink (input valid, input pixel_bit, input frame_start, output ready);
endinterface

interface zpnc_rsp_if import zpnc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ROW_OUT_W-1:0] center_row;
   logic [COL_OUT_W-1:0] center_col;
   logic [COUNT_W-1:0]   ones_around;

   modport source (output valid, output center_row, output center_col, output ones_around,
                   input ready);
   modport sink (input valid, input center_row, input center_col, input ones_around,
                 output ready);
endinterface

[hdl/zpnc_position.sv]
// Frame size registers and raster position tracking for incoming pixels.
module zpnc_position import zpnc_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
   localparam int COLW = $clog2(MAX_WIDTH),
   localparam int ROWW = $clog2(MAX_HEIGHT)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata,
   input  logic                   accept,
   input  logic                   pixel_bit,
   input  logic                   frame_start,
   output logic [COLW-1:0]        rd_addr,
   output zpnc_item_type          item
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int CXW = COLW + 1;
   localparam int RXW = ROWW + 1;
   localparam int RESET_WID = (RESET_FRAME_SIZE > MAX_WIDTH) ? MAX_WIDTH : RESET_FRAME_SIZE;
   localparam int RESET_HEI = (RESET_FRAME_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RESET_FRAME_SIZE;

   logic [CW-1:0]   wid_ff, wid_in;
   logic [HW-1:0]   hei_ff, hei_in;
   logic [COLW-1:0] col_ff, col_in;
   logic [ROWW-1:0] row_ff, row_in;
   logic [COLW-1:0] col_cur;
   logic [ROWW-1:0] row_cur;
   logic [CXW-1:0]  col_next;
   logic [RXW-1:0]  row_next;
   logic [COLW-1:0] col_less;
   logic [ROWW-1:0] row_less;

   // Sizes are held already clamped, since only the clamped values are ever used.
   always_comb begin
      wid_in = wid_ff;
      hei_in = hei_ff;
      if (csr_we && csr_index == CSR_FRAME_WIDTH) begin
         if (csr_wdata < CFG_W'(MIN_FRAME_SIZE)) begin
            wid_in = CW'(MIN_FRAME_SIZE);
         end else if (32'(csr_wdata) > MAX_WIDTH) begin
            wid_in = CW'(MAX_WIDTH);
         end else begin
            wid_in = CW'(csr_wdata);
         end
      end
      if (csr_we && csr_index == CSR_FRAME_HEIGHT) begin
         if (csr_wdata < CFG_W'(MIN_FRAME_SIZE)) begin
            hei_in = HW'(MIN_FRAME_SIZE);
         end else if (32'(csr_wdata) > MAX_HEIGHT) begin
            hei_in = HW'(MAX_HEIGHT);
         end else begin
            hei_in = HW'(csr_wdata);
         end
      end
   end

   always_comb begin
      col_cur  = frame_start ? '0 : col_ff;
      row_cur  = frame_start ? '0 : row_ff;
      col_next = CXW'(col_cur) + CXW'(1);
      row_next = RXW'(row_cur) + RXW'(1);
      col_less = col_cur - COLW'(1);
      row_less = row_cur - ROWW'(1);

      if (col_next >= CXW'(wid_ff)) begin
         col_in = '0;
         row_in = (row_next >= RXW'(hei_ff)) ? '0 : row_next[ROWW-1:0];
      end else begin
         col_in = col_next[COLW-1:0];
         row_in = (RXW'(row_cur) >= RXW'(hei_ff)) ? '0 : row_cur;
      end

      rd_addr = col_cur;

      item.pixel_bit   = pixel_bit;
      item.frame_start = frame_start;
      item.report_ok   = (row_cur >= ROWW'(2)) && (col_cur >= COLW'(2)) &&
                         (CXW'(col_cur) < CXW'(wid_ff)) && (RXW'(row_cur) < RXW'(hei_ff));
      item.center_row  = ROW_OUT_W'(row_less);
      item.center_col  = COL_OUT_W'(col_less);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wid_ff <= CW'(RESET_WID);
         hei_ff <= HW'(RESET_HEI);
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         wid_ff <= wid_in;
         hei_ff <= hei_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   a_col_in_store: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < MAX_WIDTH && 32'(row_ff) < MAX_HEIGHT)
      else $error("raster position beyond the line store depth or the frame height limit");

endmodule

[hdl/zpnc_line_store.sv]
// Line store memory holding the two previous rows, with same-address forwarding.
module zpnc_line_store import zpnc_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
   localparam int COLW = $clog2(MAX_WIDTH)
) (
   input  logic            clock,
   input  logic            accept,
   input  logic [COLW-1:0] rd_addr,
   input  logic            pixel_bit,
   input  logic            advance,
   output zpnc_column_type column
);

   zpnc_column_type mem [MAX_WIDTH];

   logic [COLW-1:0] addr_ff;
   logic            pixel_ff;
   zpnc_column_type rd_ff;
   logic            fwd_ff;
   zpnc_column_type fwd_data_ff;
   zpnc_column_type wr_data;

   // The middle row moves up and the pixel in the stage register becomes the new middle row.
   always_comb begin
      column         = fwd_ff ? fwd_data_ff : rd_ff;
      wr_data.upper  = column.middle;
      wr_data.middle = pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mem[addr_ff] <= wr_data;
      end
      if (accept) begin
         rd_ff       <= mem[rd_addr];
         addr_ff     <= rd_addr;
         pixel_ff    <= pixel_bit;
         fwd_ff      <= advance && (addr_ff == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

endmodule

[hdl/zpnc_window.sv]
// Stage register, 3x3 window, neighbor count and result register.
module zpnc_window import zpnc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  zpnc_item_type   item,
   input  zpnc_column_type column,
   output logic            in_ready,
   output logic            advance,
   zpnc_rsp_if.source      rsp
);

   logic                 s1_valid_ff;
   zpnc_item_type        item_ff;
   logic [WINDOW_W-1:0]  win_ff;
   logic [WINDOW_W-1:0]  win_base;
   logic [WINDOW_W-1:0]  win_in;
   logic                 hit;
   logic                 out_valid_ff;
   logic [ROW_OUT_W-1:0] row_ff;
   logic [COL_OUT_W-1:0] col_ff;
   logic [COUNT_W-1:0]   ones_ff;

   always_comb begin
      win_base = item_ff.frame_start ? '0 : win_ff;
      win_in   = {item_ff.pixel_bit, column.middle, column.upper, win_base[WINDOW_W-1:3]};
      hit      = item_ff.report_ok && !win_in[CENTER_BIT];
      advance  = s1_valid_ff && (!hit || !out_valid_ff || rsp.ready);
      in_ready = !s1_valid_ff || advance;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.center_row  = row_ff;
   assign rsp.center_col  = col_ff;
   assign rsp.ones_around = ones_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         win_ff       <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            win_ff <= win_in;
         end
         if (advance && hit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         item_ff <= item;
      end
      if (advance && hit) begin
         row_ff  <= item_ff.center_row;
         col_ff  <= item_ff.center_col;
         ones_ff <= count_neighbors(win_in);
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ones_ff <= COUNT_W'(NEIGHBORS))
      else $error("neighbor count above eight");

   a_hit_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && hit && out_valid_ff && !rsp.ready |=> s1_valid_ff && $stable(item_ff))
      else $error("pending result dropped while the output was stalled");

   a_hit_shown: assert property (@(posedge clock) disable iff (reset)
      advance && hit |=> out_valid_ff)
      else $error("reported pixel did not reach the result register");

endmodule

[hdl/zero_pixel_neighbor_count_unit.sv]
// Top level of the zero pixel neighbor count unit.
// A result passes from the stage register into the result register, which drives the rsp
// channel; the stage holds while the result register is full and not taken.
// Throughput: one pixel transaction per clock while the stage is not held, set by the line
// store memory, which does one read and one write per cycle.
// Reset: positions and window clear, frame size returns to 8 x 8; line stores are not cleared.
module zero_pixel_neighbor_count_unit import zpnc_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   zpnc_req_if.sink               req_ch,
   zpnc_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   localparam int COLW = $clog2(MAX_WIDTH);

   // A pixel transaction is taken whenever the stage register is empty or moving on.
   logic            accept;
   logic            in_ready;
   logic            advance;
   logic [COLW-1:0] rd_addr;
   zpnc_item_type   item;
   zpnc_column_type column;

   assign req_ch.ready = in_ready;
   assign accept = req_ch.valid && in_ready;

   // The position tracker resolves the pixel's row and column, including a frame start,
   // and decides whether a full neighborhood around the window center lies in the frame.
   zpnc_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .pixel_bit   (req_ch.pixel_bit),
      .frame_start (req_ch.frame_start),
      .rd_addr     (rd_addr),
      .item        (item)
   );

   // The line store is read at the acceptance edge and written back when the pixel
   // leaves the stage register. When the next pixel reads the column being written in
   // that same cycle, the written value is forwarded in place of the stale read.
   zpnc_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock     (clock),
      .accept    (accept),
      .rd_addr   (rd_addr),
      .pixel_bit (req_ch.pixel_bit),
      .advance   (advance),
      .column    (column)
   );

   // The window stage shifts in the new column, and if the center pixel is zero and its
   // neighborhood lies in the frame it counts the eight neighbors into the result register.
   // It only stalls when it has a result to hand over and the result register is still full.
   zpnc_window u_window (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (item),
      .column   (column),
      .in_ready (in_ready),
      .advance  (advance),
      .rsp      (rsp_ch)
   );

endmodule

[tb/zero_pixel_neighbor_count_unit_tb.sv]
// Self-checking testbench for the zero pixel neighbor count unit.
module zero_pixel_neighbor_count_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import zpnc_pkg::*;

   // Pixel transactions to send in all, directed frames included; the random part stops once
   // it is passed. The idling mix changes at each third of it.
   localparam int ITEM_TARGET = 1200;

   // Directed frames, one bit per pixel in raster order (bit 0 is the top left pixel).
   // The first has a zero center with all eight neighbors set, the second is all zeros,
   // the third is a cross whose center sees four neighbors set.
   localparam logic [8:0] DIRECTED_FRAMES [3] = '{9'h1EF, 9'h000, 9'h0AA};

   // One expected result: the zero pixel's position and its count of set neighbors.
   typedef struct packed {
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] col;
      logic [COUNT_W-1:0]   ones;
   } neighbor_report_type;

   // Tracks the unit's line stores, window and raster position, works out which accepted
   // pixels must produce a neighbor count, and checks the counts that come back in order.
   class zero_pixel_ledger;
      bit                   upper_row [DEFAULT_MAX_WIDTH];
      bit                   middle_row [DEFAULT_MAX_WIDTH];
      logic [WINDOW_W-1:0]  window;
      int                   col_pos;
      int                   row_pos;
      logic [CFG_W-1:0]     width_reg;
      logic [CFG_W-1:0]     height_reg;
      neighbor_report_type  pending_reports [$];
      int                   mismatches;
      int                   reports_checked;

      function new();
         foreach (upper_row[i]) begin
            upper_row[i] = 1'b0;
            middle_row[i] = 1'b0;
         end
         window = '0;
         col_pos = 0;
         row_pos = 0;
         width_reg = CFG_W'(RESET_FRAME_SIZE);
         height_reg = CFG_W'(RESET_FRAME_SIZE);
         mismatches = 0;
         reports_checked = 0;
      endfunction

      // Out-of-range register values saturate to the legal frame extent.
      static function int frame_extent(logic [CFG_W-1:0] value, int top);
         if (value < MIN_FRAME_SIZE) return MIN_FRAME_SIZE;
         if (value > top) return top;
         return value;
      endfunction

      function void set_reg(csr_index_type index, logic [CFG_W-1:0] value);
         if (index == CSR_FRAME_WIDTH) width_reg = value;
         else height_reg = value;
      endfunction

      function int pending_count();
         return pending_reports.size();
      endfunction

      function void take_pixel(bit pix, bit start);
         int                  width;
         int                  height;
         int                  c;
         int                  r;
         bit                  up;
         bit                  mid;
         neighbor_report_type rep;
         width = frame_extent(width_reg, DEFAULT_MAX_WIDTH);
         height = frame_extent(height_reg, DEFAULT_MAX_HEIGHT);
         if (start) begin
            col_pos = 0;
            row_pos = 0;
            window = '0;
         end
         c = col_pos;
         r = row_pos;
         if (c >= DEFAULT_MAX_WIDTH) c = 0;
         up = upper_row[c];
         mid = middle_row[c];
         // Shift a new right column in: top row low, the incoming pixel at the bottom.
         window = {pix, mid, up, window[WINDOW_W-1:3]};
         upper_row[c] = mid;
         middle_row[c] = pix;
         // The center is one row up and one column left of the incoming pixel.
         if (r >= 2 && c >= 2 && c < width && r < height && !window[CENTER_BIT]) begin
            rep.row = ROW_OUT_W'(r - 1);
            rep.col = COL_OUT_W'(c - 1);
            rep.ones = COUNT_W'($countones(window & NEIGHBOR_MASK));
            pending_reports.push_back(rep);
         end
         c++;
         if (c >= width) begin
            c = 0;
            r++;
            if (r >= height) r = 0;
         end else if (r >= height) begin
            r = 0;
         end
         col_pos = c;
         row_pos = r;
      endfunction

      task report(string what);
         $display("ERROR at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_result(logic [ROW_OUT_W-1:0] row, logic [COL_OUT_W-1:0] col,
                        logic [COUNT_W-1:0] ones);
         neighbor_report_type want;
         if (pending_reports.size() == 0) begin
            report($sformatf("unexpected result row %0d col %0d ones %0d", row, col, ones));
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            if (row !== want.row)
               report($sformatf("center_row %0d, expected %0d", row, want.row));
            if (col !== want.col)
               report($sformatf("center_col %0d, expected %0d", col, want.col));
            if (ones !== want.ones)
               report($sformatf("ones_around %0d at row %0d col %0d, expected %0d",
                                ones, want.row, want.col, want.ones));
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wdata;

   zpnc_req_if req_if ();
   zpnc_rsp_if rsp_if ();

   zero_pixel_ledger ledger;
   int               items_sent = 0;
   int               size_settings = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;

   zero_pixel_neighbor_count_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver decides at every falling edge whether it takes a result in the next cycle.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Every result transaction is checked against the oldest expected count. Outputs are
   // sampled at the rising edge, before the unit's own updates of that edge land.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         ledger.check_result(rsp_if.center_row, rsp_if.center_col, rsp_if.ones_around);
   end

   // Offers one pixel, with random idle cycles ahead of it, and holds it until it is taken.
   // Enters and leaves at a falling edge; valid stays high so back-to-back pixels need no
   // second assignment to it within a time step.
   task automatic send_pixel(input bit pix, input bit start);
      if (items_sent < ITEM_TARGET / 3) begin
         send_idle_pct = 34;
         recv_idle_pct = 80;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
         send_idle_pct = 80;
         recv_idle_pct = 34;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.pixel_bit <= pix;
      req_if.frame_start <= start;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      ledger.take_pixel(pix, start);
      items_sent++;
      @(negedge clock);
   endtask

   // Writes the width register and then the height register; the unit is idle when called.
   task automatic set_frame_size(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height);
      csr_we <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= width;
      @(posedge clock);
      ledger.set_reg(CSR_FRAME_WIDTH, width);
      @(negedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= height;
      @(posedge clock);
      ledger.set_reg(CSR_FRAME_HEIGHT, height);
      @(negedge clock);
      csr_we <= 1'b0;
      size_settings++;
   endtask

   // Stops offering pixels and waits until every expected count has come back. A pixel that
   // produces no count may still sit in the unit's stage, so the task keeps waiting after them.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (ledger.pending_count() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Mostly small sizes; now and then a border value or one that must saturate. With narrow
   // set the result stays at 3 or 4 so that a long frame side keeps the frame short.
   function automatic logic [CFG_W-1:0] pick_size_reg(input bit narrow);
      if (narrow) return CFG_W'($urandom_range(0, 4));
      if ($urandom_range(99) < 75) return CFG_W'($urandom_range(3, 9));
      case ($urandom_range(5))
         0: return CFG_W'(0);
         1: return CFG_W'(2);
         2: return CFG_W'(63);
         3: return CFG_W'(64);
         4: return CFG_W'(65);
         default: return '1;
      endcase
   endfunction

   initial begin
      int               active_w;
      int               active_h;
      int               frames;
      int               len;
      int               ones_pct;
      int               phase_index;
      logic [CFG_W-1:0] w_reg;
      logic [CFG_W-1:0] h_reg;
      bit               force_start;
      bit               start;

      ledger = new();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_FRAME_WIDTH;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.pixel_bit = 1'b0;
      req_if.frame_start = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: register values below the minimum saturate to a 3 x 3 frame. The
      // second frame has no frame start and relies on the position wrapping by itself; the
      // third restarts the frame explicitly.
      set_frame_size(CFG_W'(1), CFG_W'(2));
      active_w = 3;
      active_h = 3;
      for (int f = 0; f < 3; f++) begin
         for (int i = 0; i < 9; i++)
            send_pixel(DIRECTED_FRAMES[f][i], f != 1 && i == 0);
      end
      wait_idle();

      // Random part: each phase may pick a new frame size and then streams whole frames with
      // random content, with some frames cut short, some continuing without a frame start,
      // and a rare frame start in the middle of a frame.
      phase_index = 0;
      while (items_sent < ITEM_TARGET) begin
         force_start = 1'b0;
         if (phase_index < 2 || $urandom_range(99) < 80) begin
            if (phase_index == 0) begin
               w_reg = '1;
               h_reg = '0;
            end else if (phase_index == 1) begin
               w_reg = '0;
               h_reg = '1;
            end else begin
               w_reg = pick_size_reg(1'b0);
               h_reg = pick_size_reg(
                  zero_pixel_ledger::frame_extent(w_reg, DEFAULT_MAX_WIDTH) > 16);
               if (zero_pixel_ledger::frame_extent(h_reg, DEFAULT_MAX_HEIGHT) > 16 &&
                   zero_pixel_ledger::frame_extent(w_reg, DEFAULT_MAX_WIDTH) > 4)
                  w_reg = pick_size_reg(1'b1);
            end
            set_frame_size(w_reg, h_reg);
            // Growing the width in mid-frame would read line store columns that were never
            // filled, so a wider frame always begins with a frame start. Height changes and
            // narrower widths may take effect in the middle of a frame.
            if (zero_pixel_ledger::frame_extent(w_reg, DEFAULT_MAX_WIDTH) > active_w)
               force_start = 1'b1;
            active_w = zero_pixel_ledger::frame_extent(w_reg, DEFAULT_MAX_WIDTH);
            active_h = zero_pixel_ledger::frame_extent(h_reg, DEFAULT_MAX_HEIGHT);
         end
         phase_index++;

         frames = (active_w * active_h > 100) ? 1 : $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            len = active_w * active_h;
            if ($urandom_range(99) < 15) len = $urandom_range(1, len - 1);
            ones_pct = 10 + 40 * $urandom_range(2);
            for (int i = 0; i < len; i++) begin
               if (i == 0) start = force_start || ($urandom_range(99) < 85);
               else start = ($urandom_range(149) == 0);
               force_start = 1'b0;
               send_pixel($urandom_range(99) < ones_pct, start);
            end
         end
         wait_idle();
      end

      // Let any stray result show up before the verdict.
      repeat (8) @(posedge clock);

      $display("Sent %0d pixel transactions under %0d frame size settings; %0d counts checked.",
               items_sent, size_settings, ledger.reports_checked);
      $display("Sizes spanned saturating, border and small values; both sides idled and stalled.");
      if (ledger.mismatches == 0) begin
         $display("zero_pixel_neighbor_count_unit: match");
      end else begin
         $display("zero_pixel_neighbor_count_unit: mismatch");
      end
      $finish;
   end

   // Safety net against a hung handshake: far longer than the slowest correct run.
   initial begin
      #5ms;
      $display("Timed out with %0d counts still expected.", ledger.pending_count());
      $display("zero_pixel_neighbor_count_unit: mismatch");
      $finish;
   end

endmodule

[files.f]
hdl/zpnc_pkg.sv
hdl/zpnc_if.sv
hdl/zpnc_position.sv
hdl/zpnc_line_store.sv
hdl/zpnc_window.sv
hdl/zero_pixel_neighbor_count_unit.sv
tb/zero_pixel_neighbor_count_unit_tb.sv
